// ===== rtl/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helpers for the HSV to RGB888/RGB565 converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // Hue is in 1/64 degree: a full turn and one 60 degree sector.
   localparam logic [14:0] HUE_FULL   = 15'd23040;
   localparam logic [11:0] HUE_SECTOR = 12'd3840;

   // Saturation and value are Q8, 256 is 1.0.
   localparam logic [8:0]  ONE_Q8     = 9'd256;
   localparam logic [7:0]  CH_MAX     = 8'd255;

   // ceil(2^24 / 15): exact floor division by 15 for dividends below 2^20.
   localparam int          RECIP_SHIFT = 24;
   localparam logic [20:0] RECIP15     = 21'd1118482;

   // Hue sectors, named by the colors at their start and end.
   localparam logic [2:0] SEC_RED_YEL   = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN   = 3'd1;
   localparam logic [2:0] SEC_GRN_CYAN  = 3'd2;
   localparam logic [2:0] SEC_CYAN_BLUE = 3'd3;
   localparam logic [2:0] SEC_BLUE_MAG  = 3'd4;
   localparam logic [2:0] SEC_MAG_RED   = 3'd5;

   // Input transaction.
   typedef struct packed {
      logic [14:0] hue;
      logic [8:0]  saturation;
      logic [8:0]  brightness;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [23:0] rgb888;
      logic [15:0] rgb565_swapped;
   } rsp_type;

   // After the front stage: sector, distance term, chroma and offset in Q16.
   typedef struct packed {
      logic [2:0]  sector;
      logic [11:0] span;
      logic [16:0] chroma;
      logic [16:0] offset;
   } front_type;

   // After the product stage: c*g / 256.
   typedef struct packed {
      logic [2:0]  sector;
      logic [19:0] prod;
      logic [16:0] chroma;
      logic [16:0] offset;
   } prod_type;

   // After the quotient stage: secondary component x.
   typedef struct packed {
      logic [2:0]  sector;
      logic [16:0] second;
      logic [16:0] chroma;
      logic [16:0] offset;
   } comp_type;

endpackage

`default_nettype wire

// ===== rtl/hsv2rgb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_front
// First stage: hue wrap, input clamps, sector decode, chroma and offset.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_stall,
   input  hsv2rgb_pkg::req_type    in_data,
   output logic                    out_valid,
   input  wire                     out_stall,
   output hsv2rgb_pkg::front_type  out_data
);

   logic                   valid_ff;
   hsv2rgb_pkg::front_type data_ff;
   hsv2rgb_pkg::front_type data_in;
   logic                   load;

   logic [14:0] hue_wrap;
   logic [8:0]  sat_cl;
   logic [8:0]  val_cl;
   logic [2:0]  sector;
   logic [14:0] base;
   logic [11:0] pos;
   logic [17:0] prod_sv;

   // Wrap hue into one turn and clamp saturation and value to one.
   always_comb begin
      hue_wrap = (in_data.hue >= hsv2rgb_pkg::HUE_FULL) ?
                 (in_data.hue - hsv2rgb_pkg::HUE_FULL) : in_data.hue;
      sat_cl   = (in_data.saturation > hsv2rgb_pkg::ONE_Q8) ?
                 hsv2rgb_pkg::ONE_Q8 : in_data.saturation;
      val_cl   = (in_data.brightness > hsv2rgb_pkg::ONE_Q8) ?
                 hsv2rgb_pkg::ONE_Q8 : in_data.brightness;
   end

   // The sector is the number of sector boundaries at or below the hue.
   always_comb begin
      sector = 3'(hue_wrap >= 15'(1 * hsv2rgb_pkg::HUE_SECTOR))
             + 3'(hue_wrap >= 15'(2 * hsv2rgb_pkg::HUE_SECTOR))
             + 3'(hue_wrap >= 15'(3 * hsv2rgb_pkg::HUE_SECTOR))
             + 3'(hue_wrap >= 15'(4 * hsv2rgb_pkg::HUE_SECTOR))
             + 3'(hue_wrap >= 15'(5 * hsv2rgb_pkg::HUE_SECTOR));
      base   = 15'({12'd0, sector} * 15'(hsv2rgb_pkg::HUE_SECTOR));
      pos    = 12'(hue_wrap - base);
   end

   // Odd sectors run the secondary component down instead of up.
   always_comb begin
      prod_sv        = sat_cl * val_cl;
      data_in.sector = sector;
      data_in.span   = sector[0] ? (hsv2rgb_pkg::HUE_SECTOR - pos) : pos;
      data_in.chroma = prod_sv[16:0];
      data_in.offset = {val_cl, 8'd0} - prod_sv[16:0];
   end

   // Stage register; it loads whenever it is empty or its content moves on.
   assign in_stall = valid_ff & out_stall;
   assign load     = ~in_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_xcalc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_xcalc
// Two stages for the secondary component: x = floor(c * g / 3840).
// The first stage forms c * g / 256, the second divides by 15 by reciprocal.
// ----------------------------------------------------------------------------
module hsv2rgb_xcalc (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_stall,
   input  hsv2rgb_pkg::front_type  in_data,
   output logic                    out_valid,
   input  wire                     out_stall,
   output hsv2rgb_pkg::comp_type   out_data
);

   logic                   prod_valid_ff;
   hsv2rgb_pkg::prod_type  prod_ff;
   hsv2rgb_pkg::prod_type  prod_in;
   logic                   prod_stall;

   logic                   comp_valid_ff;
   hsv2rgb_pkg::comp_type  comp_ff;
   hsv2rgb_pkg::comp_type  comp_in;

   logic [28:0] cg_full;
   logic [40:0] quot_full;

   // Product stage: c * g stays below 2^28, so bits 27:8 hold it over 256.
   always_comb begin
      cg_full        = in_data.chroma * in_data.span;
      prod_in.sector = in_data.sector;
      prod_in.prod   = cg_full[27:8];
      prod_in.chroma = in_data.chroma;
      prod_in.offset = in_data.offset;
   end

   // Quotient stage: floor(q / 15) as a multiply by a rounded-up reciprocal.
   always_comb begin
      quot_full      = prod_ff.prod * hsv2rgb_pkg::RECIP15;
      comp_in.sector = prod_ff.sector;
      comp_in.second = quot_full[hsv2rgb_pkg::RECIP_SHIFT +: 17];
      comp_in.chroma = prod_ff.chroma;
      comp_in.offset = prod_ff.offset;
   end

   // Stall chain: a stage holds only when it is full and the next one holds.
   assign prod_stall = comp_valid_ff & out_stall;
   assign in_stall   = prod_valid_ff & prod_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         comp_valid_ff <= 1'b0;
      end else begin
         if (!in_stall) begin
            prod_valid_ff <= in_valid;
         end
         if (!prod_stall) begin
            comp_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         prod_ff <= prod_in;
      end
      if (!prod_stall && prod_valid_ff) begin
         comp_ff <= comp_in;
      end
   end

   assign out_valid = comp_valid_ff;
   assign out_data  = comp_ff;

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pack
// Last stage: channel ordering, scale to 8 bits, RGB888 and swapped RGB565.
// ----------------------------------------------------------------------------
module hsv2rgb_pack (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_stall,
   input  hsv2rgb_pkg::comp_type   in_data,
   output logic                    out_valid,
   input  wire                     out_stall,
   output hsv2rgb_pkg::rsp_type    out_data
);

   logic                   valid_ff;
   hsv2rgb_pkg::rsp_type   data_ff;
   hsv2rgb_pkg::rsp_type   data_in;

   logic [16:0] red_q;
   logic [16:0] grn_q;
   logic [16:0] blu_q;
   logic [7:0]  red_ch;
   logic [7:0]  grn_ch;
   logic [7:0]  blu_ch;
   logic [15:0] p565;

   // Scale a Q16 value to 0..255 as floor(q * 255 / 65536), saturated.
   function automatic logic [7:0] to_channel(input logic [16:0] q);
      logic [24:0] scaled;
      scaled = {q, 8'd0} - 25'(q);
      to_channel = (scaled[24:16] > 9'(hsv2rgb_pkg::CH_MAX)) ?
                   hsv2rgb_pkg::CH_MAX : scaled[23:16];
   endfunction

   // Place chroma and the secondary component by sector, then add the offset.
   always_comb begin
      red_q = 17'd0;
      grn_q = 17'd0;
      blu_q = 17'd0;
      case (in_data.sector)
         hsv2rgb_pkg::SEC_RED_YEL: begin
            red_q = in_data.chroma;
            grn_q = in_data.second;
         end
         hsv2rgb_pkg::SEC_YEL_GRN: begin
            red_q = in_data.second;
            grn_q = in_data.chroma;
         end
         hsv2rgb_pkg::SEC_GRN_CYAN: begin
            grn_q = in_data.chroma;
            blu_q = in_data.second;
         end
         hsv2rgb_pkg::SEC_CYAN_BLUE: begin
            grn_q = in_data.second;
            blu_q = in_data.chroma;
         end
         hsv2rgb_pkg::SEC_BLUE_MAG: begin
            red_q = in_data.second;
            blu_q = in_data.chroma;
         end
         default: begin
            red_q = in_data.chroma;
            blu_q = in_data.second;
         end
      endcase
      red_ch = to_channel(red_q + in_data.offset);
      grn_ch = to_channel(grn_q + in_data.offset);
      blu_ch = to_channel(blu_q + in_data.offset);
   end

   // Pack both output formats; the 565 word goes out with its bytes swapped.
   always_comb begin
      p565                   = {red_ch[7:3], grn_ch[7:2], blu_ch[7:3]};
      data_in.rgb888         = {red_ch, grn_ch, blu_ch};
      data_in.rgb565_swapped = {p565[7:0], p565[15:8]};
   end

   // Output register.
   assign in_stall = valid_ff & out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb565_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb565_converter
// Converts a pixel color from HSV to RGB888 and byte-swapped RGB565.
// ----------------------------------------------------------------------------
// The converter takes one transaction per clock while req_stall is low.
// The work runs through four register stages: input clamps and sector
// decode with the 9x9 chroma product, the 17x12 product c*g over 256, the
// reciprocal multiply that divides it by 15, and the channel scaling and
// packing into the output register. Every stage holds its own valid bit, so
// a stall at the output only stops stages that are full; empty stages keep
// taking new transactions. Hue is in 1/64 degree and wraps at 360 degrees;
// saturation and value are Q8 and clamp at 1.0.
// ----------------------------------------------------------------------------
module hsv_to_rgb565_converter (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  hsv2rgb_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output hsv2rgb_pkg::rsp_type  rsp_data
);

   logic                   front_valid;
   logic                   front_stall;
   hsv2rgb_pkg::front_type front_data;
   logic                   comp_valid;
   logic                   comp_stall;
   hsv2rgb_pkg::comp_type  comp_data;

   // Clamp, wrap and sector decode.
   hsv2rgb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_stall (front_stall),
      .out_data  (front_data)
   );

   // Secondary component.
   hsv2rgb_xcalc u_xcalc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_data),
      .out_valid (comp_valid),
      .out_stall (comp_stall),
      .out_data  (comp_data)
   );

   // Channel scaling and output formats.
   hsv2rgb_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (comp_valid),
      .in_stall  (comp_stall),
      .in_data   (comp_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // The swapped 565 word always matches the top bits of the 888 word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.rgb565_swapped ==
         {rsp_data.rgb888[12:10], rsp_data.rgb888[7:3],
          rsp_data.rgb888[23:19], rsp_data.rgb888[15:13]})
      else $error("rgb565 result does not match rgb888 result");

   // With the output register empty, nothing in the pipeline may hold input.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while the output register is empty");

   // A result held by the output stall keeps the pipeline from taking a new
   // transaction only when every stage is full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && comp_valid && front_valid)
      else $error("input stalled with an empty stage in the pipeline");
`endif

endmodule

`default_nettype wire

// ===== bench/hsv_to_rgb565_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb565_checker
// Watches both channels of the HSV to RGB565 converter. Every accepted pixel
// is converted here in plain integer arithmetic, and each accepted result is
// compared field by field with the oldest outstanding color.
// ----------------------------------------------------------------------------
module hsv_to_rgb565_checker
   import hsv2rgb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count
);

   rsp_type expected_colors[$];
   rsp_type oldest_color;
   int      mismatches = 0;

   initial pending_count = 0;
   assign error_count = mismatches;

   // Scales a Q16 level to an 8-bit channel, saturating at full scale.
   function automatic logic [7:0] q16_to_level(input int unsigned level);
      longint unsigned scaled;
      scaled = level;
      scaled = (scaled * CH_MAX) >> 16;
      return (scaled > CH_MAX) ? CH_MAX : scaled[7:0];
   endfunction

   // Converts one pixel to its RGB888 word and byte-swapped RGB565 word.
   function automatic rsp_type convert_hsv(input req_type pixel);
      int unsigned hue, sat, val, sector, pos, span;
      int unsigned chroma, offset, second, red_q, grn_q, blu_q;
      logic [7:0]  red, grn, blu;
      logic [15:0] word565;
      rsp_type     color;
      hue = pixel.hue;
      sat = pixel.saturation;
      val = pixel.brightness;

      // Hue wraps once past a full turn; saturation and value clamp at 1.0.
      if (hue >= HUE_FULL) hue = hue - HUE_FULL;
      if (sat > ONE_Q8) sat = ONE_Q8;
      if (val > ONE_Q8) val = ONE_Q8;

      chroma = val * sat;
      offset = (val << 8) - chroma;
      sector = hue / HUE_SECTOR;
      pos    = hue % HUE_SECTOR;
      span   = (sector % 2 == 1) ? (HUE_SECTOR - pos) : pos;
      second = (chroma * span) / HUE_SECTOR;

      // The sector decides which channel gets chroma, the secondary or zero.
      case (3'(sector))
         SEC_RED_YEL: begin
            red_q = chroma; grn_q = second; blu_q = 0;
         end
         SEC_YEL_GRN: begin
            red_q = second; grn_q = chroma; blu_q = 0;
         end
         SEC_GRN_CYAN: begin
            red_q = 0; grn_q = chroma; blu_q = second;
         end
         SEC_CYAN_BLUE: begin
            red_q = 0; grn_q = second; blu_q = chroma;
         end
         SEC_BLUE_MAG: begin
            red_q = second; grn_q = 0; blu_q = chroma;
         end
         default: begin
            red_q = chroma; grn_q = 0; blu_q = second;
         end
      endcase

      red = q16_to_level(red_q + offset);
      grn = q16_to_level(grn_q + offset);
      blu = q16_to_level(blu_q + offset);

      word565 = {red[7:3], grn[7:2], blu[7:3]};
      color.rgb888         = {red, grn, blu};
      color.rgb565_swapped = {word565[7:0], word565[15:8]};
      return color;
   endfunction

   // Counts a failure; only the first few are described in the log.
   task automatic flag_error(input string what, input logic [23:0] want, got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
   endtask

   // Results are checked before new pixels are queued, so a result can never
   // be matched against a transaction accepted on the same edge.
   always @(posedge clock) begin
      if (reset) begin
         expected_colors.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               flag_error("result with no pixel outstanding", '0, rsp_data.rgb888);
            end else begin
               oldest_color = expected_colors.pop_front();
               if (rsp_data.rgb888 !== oldest_color.rgb888)
                  flag_error("rgb888", oldest_color.rgb888, rsp_data.rgb888);
               if (rsp_data.rgb565_swapped !== oldest_color.rgb565_swapped)
                  flag_error("rgb565_swapped", oldest_color.rgb565_swapped,
                             rsp_data.rgb565_swapped);
            end
         end
         if (req_valid && !req_stall)
            expected_colors.push_back(convert_hsv(req_data));
         pending_count <= expected_colors.size();
      end
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the HSV to RGB565 converter with a directed set of colors (sector
// edges, hue wrap, clamped saturation and value) and then with random pixels
// in bursts, while the result side stalls in changing patterns. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import hsv2rgb_pkg::*;

   localparam int RANDOM_PIXELS = 1150;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;

   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   hsv_to_rgb565_converter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   hsv_to_rgb565_checker color_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   // The result side switches between stall patterns after random run lengths:
   // never, rarely, mostly, and toggling on and off.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   // Offers one pixel and returns at the edge that accepts it.
   task automatic send_pixel(input req_type pixel);
      req_data  <= pixel;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops sending until every outstanding result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Picks a saturation or value code: mostly in range, some at the extremes,
   // some above 1.0 to exercise the clamp.
   function automatic logic [8:0] pick_level();
      int unsigned choice;
      choice = $urandom_range(0, 99);
      if (choice < 60)
         return 9'($urandom_range(0, 256));
      else if (choice < 78)
         return ($urandom_range(0, 1) == 1) ? ONE_Q8 : 9'd0;
      else
         return 9'($urandom_range(257, 511));
   endfunction

   initial begin
      req_type     directed [22];
      req_type     pixel;
      int unsigned choice, burst, gap, sent, idx;

      // Primary and secondary colors, sector edges, wrap and clamp cases.
      directed[0]  = '{hue: 15'd0,     saturation: 9'd256, brightness: 9'd256};
      directed[1]  = '{hue: 15'd3839,  saturation: 9'd256, brightness: 9'd256};
      directed[2]  = '{hue: 15'd3840,  saturation: 9'd256, brightness: 9'd256};
      directed[3]  = '{hue: 15'd7680,  saturation: 9'd256, brightness: 9'd256};
      directed[4]  = '{hue: 15'd11520, saturation: 9'd256, brightness: 9'd256};
      directed[5]  = '{hue: 15'd15360, saturation: 9'd256, brightness: 9'd256};
      directed[6]  = '{hue: 15'd19200, saturation: 9'd256, brightness: 9'd256};
      directed[7]  = '{hue: 15'd23039, saturation: 9'd256, brightness: 9'd256};
      directed[8]  = '{hue: 15'd23040, saturation: 9'd256, brightness: 9'd256};
      directed[9]  = '{hue: 15'd32767, saturation: 9'd256, brightness: 9'd256};
      directed[10] = '{hue: 15'd1920,  saturation: 9'd128, brightness: 9'd200};
      directed[11] = '{hue: 15'd5760,  saturation: 9'd200, brightness: 9'd128};
      directed[12] = '{hue: 15'd0,     saturation: 9'd0,   brightness: 9'd256};
      directed[13] = '{hue: 15'd0,     saturation: 9'd0,   brightness: 9'd0};
      directed[14] = '{hue: 15'd16384, saturation: 9'd256, brightness: 9'd0};
      directed[15] = '{hue: 15'd9000,  saturation: 9'd511, brightness: 9'd511};
      directed[16] = '{hue: 15'd20000, saturation: 9'd257, brightness: 9'd100};
      directed[17] = '{hue: 15'd12345, saturation: 9'd100, brightness: 9'd257};
      directed[18] = '{hue: 15'd26880, saturation: 9'd255, brightness: 9'd255};
      directed[19] = '{hue: 15'd30000, saturation: 9'd1,   brightness: 9'd1};
      directed[20] = '{hue: 15'd13000, saturation: 9'd256, brightness: 9'd255};
      directed[21] = '{hue: 15'd21000, saturation: 9'd300, brightness: 9'd256};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_pixel(directed[i]);
      wait_for_drain();

      // Random pixels in bursts with gaps, now and then draining completely.
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         burst = $urandom_range(1, 40);
         for (idx = 0; idx < burst && sent < RANDOM_PIXELS; idx++) begin
            choice = $urandom_range(0, 99);
            if (choice < 65)
               pixel.hue = 15'($urandom_range(0, 23039));
            else if (choice < 80)
               pixel.hue = 15'($urandom_range(23040, 32767));
            else
               pixel.hue = 15'($urandom_range(0, 5) * HUE_SECTOR +
                               (($urandom_range(0, 1) == 1) ?
                                $urandom_range(0, 1) : $urandom_range(3838, 3839)));
            pixel.saturation = pick_level();
            pixel.brightness = pick_level();
            send_pixel(pixel);
            sent++;
         end
         if ($urandom_range(0, 99) < 3) begin
            wait_for_drain();
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("hsv_to_rgb565_converter test passed");
      else
         $display("hsv_to_rgb565_converter test failed");
      $finish;
   end

   // Hard limit on the run in case the handshake hangs.
   initial begin
      #2_000_000;
      $display("hsv_to_rgb565_converter test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_front.sv
rtl/hsv2rgb_xcalc.sv
rtl/hsv2rgb_pack.sv
rtl/hsv_to_rgb565_converter.sv
bench/hsv_to_rgb565_checker.sv
bench/testbench.sv
